/* hdl/tvs_pkg.sv */
package tvs_pkg;

  localparam int unsigned DEF_MAX_DIM     = 32;
  localparam int unsigned DEF_STORE_WORDS = 32768;
  localparam int unsigned DEF_FRAC_BITS   = 8;

  localparam int unsigned ADDR_IN_W   = 15;
  localparam int unsigned VOXEL_W     = 16;
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned SIZE_W      = 6;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned NUM_CORNERS = 8;
  localparam int unsigned CORNER_W    = 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT = 2'd3;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic LAYOUT_Z_SLOW = 1'b0;
  localparam logic LAYOUT_X_SLOW = 1'b1;

  typedef struct packed {
    logic                clear;
    logic                issue;
    logic                oob;
    logic [CORNER_W-1:0] corner;
  } mac_ctrl_t;

endpackage

/* hdl/tvs_store.sv */
module tvs_store #(
  parameter int unsigned WORDS = tvs_pkg::DEF_STORE_WORDS
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic                             re_i,
  input  logic [$clog2(WORDS)-1:0]         addr_i,
  input  logic [tvs_pkg::VOXEL_W-1:0]      wdata_i,
  output logic [tvs_pkg::VOXEL_W-1:0]      rdata_o
);
  import tvs_pkg::*;

  logic [VOXEL_W-1:0] mem_q [WORDS];
  logic [VOXEL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/tvs_mac.sv */
module tvs_mac #(
  parameter int unsigned FRAC_BITS = tvs_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tvs_pkg::mac_ctrl_t             ctrl_i,
  input  logic [FRAC_BITS-1:0]           frac_x_i,
  input  logic [FRAC_BITS-1:0]           frac_y_i,
  input  logic [FRAC_BITS-1:0]           frac_z_i,
  input  logic [tvs_pkg::VOXEL_W-1:0]    rdata_i,
  output logic [tvs_pkg::VOXEL_W-1:0]    result_o,
  output logic                           idle_o
);
  import tvs_pkg::*;

  localparam int unsigned W_W    = FRAC_BITS + 1;
  localparam int unsigned WXY_W  = 2 * W_W;
  localparam int unsigned WXYZ_W = 3 * FRAC_BITS + 1;
  localparam int unsigned PROD_W = VOXEL_W + WXYZ_W + 1;
  localparam int unsigned ACC_W  = PROD_W + 3;
  localparam logic [W_W-1:0]   ONE  = W_W'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (3 * FRAC_BITS - 1);

  logic [W_W-1:0]    wx, wy, wz;
  logic [WXY_W-1:0]  wxy_d, wxy_q;
  logic [WXYZ_W-1:0] wxyz_d, wxyz_q;
  logic              cz_q, oob_q;
  logic signed [VOXEL_W-1:0] voxel_q;
  logic signed [PROD_W-1:0]  vox_ext, wgt_ext, prod_d, prod_q;
  logic signed [ACC_W-1:0]   acc_d, acc_q, biased;
  logic              v1_q, v2_q, v3_q;

  assign wx = ctrl_i.corner[0] ? W_W'(frac_x_i) : ONE - W_W'(frac_x_i);
  assign wy = ctrl_i.corner[1] ? W_W'(frac_y_i) : ONE - W_W'(frac_y_i);
  assign wz = cz_q ? W_W'(frac_z_i) : ONE - W_W'(frac_z_i);

  assign wxy_d  = WXY_W'(wx) * WXY_W'(wy);
  assign wxyz_d = WXYZ_W'(wxy_q) * WXYZ_W'(wz);

  assign vox_ext = PROD_W'(voxel_q);
  assign wgt_ext = $signed(PROD_W'(wxyz_q));
  assign prod_d  = vox_ext * wgt_ext;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (v3_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  // pipeline: weight xy, weight xyz with voxel, product, accumulate
  always_ff @(posedge clk_i) begin
    wxy_q   <= wxy_d;
    cz_q    <= ctrl_i.corner[2];
    oob_q   <= ctrl_i.oob;
    wxyz_q  <= wxyz_d;
    voxel_q <= oob_q ? '0 : $signed(rdata_i);
    prod_q  <= prod_d;
    acc_q   <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // round half up back to the voxel format
  assign biased   = acc_q + $signed(HALF);
  assign result_o = biased[3*FRAC_BITS +: VOXEL_W];
  assign idle_o   = !(v1_q || v2_q || v3_q);

endmodule

/* hdl/tvs_seq.sv */
module tvs_seq #(
  parameter int unsigned MAX_DIM     = tvs_pkg::DEF_MAX_DIM,
  parameter int unsigned STORE_WORDS = tvs_pkg::DEF_STORE_WORDS,
  parameter int unsigned FRAC_BITS   = tvs_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [tvs_pkg::COORD_W-1:0]  x_coord_i,
  input  logic signed [tvs_pkg::COORD_W-1:0]  y_coord_i,
  input  logic signed [tvs_pkg::COORD_W-1:0]  z_coord_i,
  input  logic [tvs_pkg::SIZE_W-1:0]          size_x_i,
  input  logic [tvs_pkg::SIZE_W-1:0]          size_y_i,
  input  logic [tvs_pkg::SIZE_W-1:0]          size_z_i,
  input  logic                                layout_i,
  input  logic                                out_free_i,
  input  logic                                mac_idle_i,
  output logic                                busy_o,
  output logic                                load_o,
  output logic                                mem_re_o,
  output logic [$clog2(STORE_WORDS)-1:0]      mem_addr_o,
  output tvs_pkg::mac_ctrl_t                  mac_ctrl_o,
  output logic [FRAC_BITS-1:0]                frac_x_o,
  output logic [FRAC_BITS-1:0]                frac_y_o,
  output logic [FRAC_BITS-1:0]                frac_z_o
);
  import tvs_pkg::*;

  localparam int unsigned AW      = $clog2(STORE_WORDS);
  localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_DIM);
  localparam int unsigned ROW_W   = $clog2(MAX_DIM * MAX_DIM);
  localparam int unsigned PLANE_W = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int unsigned LIN_W   = $clog2(MAX_DIM * MAX_DIM * MAX_DIM);
  localparam int unsigned SW_W    = $clog2(STORE_WORDS + 1);
  localparam int unsigned CA_W    = (LIN_W > SW_W) ? LIN_W : SW_W;
  localparam int unsigned POS_W   = COORD_W + DIM_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROW   = 3'd1;
  localparam logic [2:0] ST_BASE  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  typedef struct packed {
    logic                 in_vol;
    logic [IDX_W-1:0]     lo;
    logic                 step;
    logic [FRAC_BITS-1:0] frac;
  } axis_t;

  function automatic logic [DIM_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W:0] ext;
    ext = (SIZE_W + 1)'(s);
    if (ext > (SIZE_W + 1)'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(s);
  endfunction

  function automatic axis_t split(input logic signed [COORD_W-1:0] c,
                                  input logic [DIM_W-1:0] sz);
    axis_t            a;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] lim;
    logic [DIM_W:0]   nxt;
    pos      = POS_W'($unsigned(c));
    lim      = POS_W'(sz - 1'b1) << FRAC_BITS;
    a.in_vol = (sz != '0) && !c[COORD_W-1] && (pos <= lim);
    a.lo     = IDX_W'(pos >> FRAC_BITS);
    nxt      = (DIM_W + 1)'(a.lo) + 1'b1;
    a.step   = nxt < (DIM_W + 1)'(sz);
    a.frac   = c[FRAC_BITS-1:0];
    return a;
  endfunction

  logic [2:0]          state_q, state_d;
  logic [CORNER_W-1:0] cnt_q, cnt_d;
  logic [DIM_W-1:0]    sx, sy, sz;
  axis_t               ax_d, ay_d, az_d, ax_q, ay_q, az_q;
  logic                z_slow;
  logic [ROW_W-1:0]    row_d, row_q;
  logic [PLANE_W-1:0]  plane_d, plane_q;
  logic [LIN_W-1:0]    base_d, base_q;
  logic [LIN_W-1:0]    stride_x, stride_y, stride_z, addr;
  logic [LIN_W-1:0]    off_x, off_y, off_z;
  logic [IDX_W-1:0]    slow_lo, fast_lo;
  logic [DIM_W-1:0]    fast_sz, plane_sz;
  logic                oob;

  assign sx = eff_size(size_x_i);
  assign sy = eff_size(size_y_i);
  assign sz = eff_size(size_z_i);

  assign ax_d = split(x_coord_i, sx);
  assign ay_d = split(y_coord_i, sy);
  assign az_d = split(z_coord_i, sz);

  assign z_slow   = (layout_i == LAYOUT_Z_SLOW);
  assign slow_lo  = z_slow ? az_q.lo : ax_q.lo;
  assign fast_lo  = z_slow ? ax_q.lo : az_q.lo;
  assign fast_sz  = z_slow ? sx : sz;
  assign plane_sz = z_slow ? sx : sz;

  assign row_d   = ROW_W'(slow_lo) * ROW_W'(sy) + ROW_W'(ay_q.lo);
  assign plane_d = PLANE_W'(plane_sz) * PLANE_W'(sy);
  assign base_d  = LIN_W'(row_q) * LIN_W'(fast_sz) + LIN_W'(fast_lo);

  assign stride_x = z_slow ? LIN_W'(1) : LIN_W'(plane_q);
  assign stride_y = LIN_W'(fast_sz);
  assign stride_z = z_slow ? LIN_W'(plane_q) : LIN_W'(1);

  assign off_x = (cnt_q[0] && ax_q.step) ? stride_x : '0;
  assign off_y = (cnt_q[1] && ay_q.step) ? stride_y : '0;
  assign off_z = (cnt_q[2] && az_q.step) ? stride_z : '0;
  assign addr  = base_q + off_x + off_y + off_z;
  assign oob   = CA_W'(addr) >= CA_W'(STORE_WORDS);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = (ax_d.in_vol && ay_d.in_vol && az_d.in_vol) ? ST_ROW : ST_DRAIN;
        end
      end
      ST_ROW: begin
        state_d = ST_BASE;
      end
      ST_BASE: begin
        state_d = ST_READ;
        cnt_d   = '0;
      end
      ST_READ: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CORNER_W'(NUM_CORNERS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_idle_i && out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      ax_q <= ax_d;
      ay_q <= ay_d;
      az_q <= az_d;
    end
    if (state_q == ST_ROW) begin
      row_q   <= row_d;
      plane_q <= plane_d;
    end
    if (state_q == ST_BASE) begin
      base_q <= base_d;
    end
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign load_o     = (state_q == ST_DRAIN) && mac_idle_i && out_free_i;
  assign mem_re_o   = (state_q == ST_READ) && !oob;
  assign mem_addr_o = AW'(addr);

  assign mac_ctrl_o.clear  = start_i;
  assign mac_ctrl_o.issue  = (state_q == ST_READ);
  assign mac_ctrl_o.oob    = oob;
  assign mac_ctrl_o.corner = cnt_q;

  assign frac_x_o = ax_q.frac;
  assign frac_y_o = ay_q.frac;
  assign frac_z_o = az_q.frac;

endmodule

/* hdl/trilinear_volume_sampler.sv */
// Trilinear volume sampler. Write transfers (operation 0) load one Q8.8 voxel into a
// single-port synchronous store. Sample transfers (operation 1) blend the eight
// neighbour voxels around a signed Q8.8 point and return one result; a point
// outside the volume returns zero. A point inside occupies the block through the
// transfer, the address multiplies, eight corner reads through the one store port,
// draining the weight and multiply-accumulate pipeline, and loading the output
// register. A finished result waits in the output register while the next transfer
// is taken; a sample cannot load while that register is still held by a stall.
module trilinear_volume_sampler #(
  parameter int unsigned MAX_DIM     = tvs_pkg::DEF_MAX_DIM,
  parameter int unsigned STORE_WORDS = tvs_pkg::DEF_STORE_WORDS,
  parameter int unsigned FRAC_BITS   = tvs_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                operation_i,
  input  logic [tvs_pkg::ADDR_IN_W-1:0]       voxel_address_i,
  input  logic signed [tvs_pkg::VOXEL_W-1:0]  voxel_value_i,
  input  logic signed [tvs_pkg::COORD_W-1:0]  x_coord_i,
  input  logic signed [tvs_pkg::COORD_W-1:0]  y_coord_i,
  input  logic signed [tvs_pkg::COORD_W-1:0]  z_coord_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tvs_pkg::VOXEL_W-1:0]  sample_value_o,
  input  logic                                cfg_we_i,
  input  logic [tvs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tvs_pkg::SIZE_W-1:0]          cfg_data_i
);
  import tvs_pkg::*;

  localparam int unsigned AW   = $clog2(STORE_WORDS);
  localparam int unsigned SW_W = $clog2(STORE_WORDS + 1);
  localparam int unsigned WA_W = (SW_W > ADDR_IN_W) ? SW_W : ADDR_IN_W;

  logic [SIZE_W-1:0]  size_x_q, size_y_q, size_z_q;
  logic               layout_q;
  logic               in_xfer, sample_start, wr_en;
  logic               seq_busy, seq_load, seq_re;
  logic [AW-1:0]      seq_addr, store_addr;
  mac_ctrl_t          mac_ctrl;
  logic [FRAC_BITS-1:0] frac_x, frac_y, frac_z;
  logic [VOXEL_W-1:0] rdata, mac_result;
  logic               mac_idle, out_free;
  logic               out_valid_q, out_valid_d;
  logic [VOXEL_W-1:0] sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_RESET;
      size_y_q <= SIZE_RESET;
      size_z_q <= SIZE_RESET;
      layout_q <= LAYOUT_Z_SLOW;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SIZE_X: size_x_q <= cfg_data_i;
        CFG_SIZE_Y: size_y_q <= cfg_data_i;
        CFG_SIZE_Z: size_z_q <= cfg_data_i;
        CFG_LAYOUT: layout_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_stall_o   = seq_busy;
  assign in_xfer      = in_valid_i && !in_stall_o;
  assign sample_start = in_xfer && (operation_i == OP_SAMPLE);
  assign wr_en        = in_xfer && (operation_i == OP_WRITE) &&
                        (WA_W'(voxel_address_i) < WA_W'(STORE_WORDS));
  assign store_addr   = seq_busy ? seq_addr : AW'(voxel_address_i);

  tvs_store #(
    .WORDS (STORE_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .re_i    (seq_re),
    .addr_i  (store_addr),
    .wdata_i (voxel_value_i),
    .rdata_o (rdata)
  );

  tvs_seq #(
    .MAX_DIM     (MAX_DIM),
    .STORE_WORDS (STORE_WORDS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sample_start),
    .x_coord_i  (x_coord_i),
    .y_coord_i  (y_coord_i),
    .z_coord_i  (z_coord_i),
    .size_x_i   (size_x_q),
    .size_y_i   (size_y_q),
    .size_z_i   (size_z_q),
    .layout_i   (layout_q),
    .out_free_i (out_free),
    .mac_idle_i (mac_idle),
    .busy_o     (seq_busy),
    .load_o     (seq_load),
    .mem_re_o   (seq_re),
    .mem_addr_o (seq_addr),
    .mac_ctrl_o (mac_ctrl),
    .frac_x_o   (frac_x),
    .frac_y_o   (frac_y),
    .frac_z_o   (frac_z)
  );

  tvs_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .frac_x_i (frac_x),
    .frac_y_i (frac_y),
    .frac_z_i (frac_z),
    .rdata_i  (rdata),
    .result_o (mac_result),
    .idle_o   (mac_idle)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (seq_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_load) begin
      sample_q <= mac_result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_value_o = $signed(sample_q);

endmodule
